### rtl/ttg_pkg.sv
// shared widths and constants for the triangle tangent generator
// used by the top level and its port checker, no dependencies
package ttg_pkg;

  localparam int POS_W = 32;
  localparam int NRM_W = 16;
  localparam int TAN_W = 16;
  localparam int ONE_Q14 = 16384;
  localparam int ALIGN_LO_BIT = 29;
  localparam int ALIGN_HI_BIT = 30;

endpackage

### rtl/triangle_tangent_generator_unit.sv
// triangle tangent generator top level: vertex store, sequencer and shared datapath
// depends on ttg_pkg
//
// Vertices are taken one beat at a time. The first two vertices of a triangle are stored
// with no result. The third vertex starts the sequencer, which drives one 32x32 multiplier
// with an accumulator, a block-alignment shifter, a one-bit-per-cycle square root and a
// one-bit-per-cycle divider. It forms the edge and uv deltas, the determinant sign and the
// raw tangent, then per vertex the normal projection, length and the three normalized
// components, and gives one result beat per vertex, the last one flagged. A zero determinant
// gives three degenerate beats and a zero length gives one, each with a zero tangent.
// The input stays stalled from the third vertex until the last result beat is taken,
// including any time the result side stalls.
module triangle_tangent_generator_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ttg_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [ttg_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [ttg_pkg::POS_W-1:0]    in_pos_z,
  input  logic signed [ttg_pkg::NRM_W-1:0]    in_norm_x,
  input  logic signed [ttg_pkg::NRM_W-1:0]    in_norm_y,
  input  logic signed [ttg_pkg::NRM_W-1:0]    in_norm_z,
  input  logic signed [ttg_pkg::POS_W-1:0]    in_tex_u,
  input  logic signed [ttg_pkg::POS_W-1:0]    in_tex_v,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ttg_pkg::TAN_W-1:0]    out_tangent_x,
  output logic signed [ttg_pkg::TAN_W-1:0]    out_tangent_y,
  output logic signed [ttg_pkg::TAN_W-1:0]    out_tangent_z,
  output logic                                out_degenerate,
  output logic                                out_last_of_triangle
);

  localparam int CW = (COORD_WIDTH < ttg_pkg::POS_W) ? COORD_WIDTH : ttg_pkg::POS_W;
  localparam logic [63:0] ALIGN_LO = 64'd1 << ttg_pkg::ALIGN_LO_BIT;
  localparam logic [63:0] ALIGN_HI = 64'd1 << ttg_pkg::ALIGN_HI_BIT;
  localparam logic [63:0] COARSE_HI = 64'd1 << (ttg_pkg::ALIGN_HI_BIT + 4);
  localparam logic [63:0] COARSE_LO = 64'd1 << (ttg_pkg::ALIGN_HI_BIT - 4);
  localparam logic [15:0] ONE_Q = 16'(ttg_pkg::ONE_Q14);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LDE, ST_AMAX, ST_ASH, ST_AAPP, ST_ADONE,
    ST_MUL, ST_ACC, ST_SQRT, ST_DIVI, ST_DIV, ST_OUT
  } state_t;

  typedef enum logic [2:0] {PH_DET, PH_W, PH_DOT, PH_R, PH_LEN} phase_t;
  typedef enum logic [1:0] {GRP_E, GRP_D, GRP_W, GRP_R} grp_t;

  function automatic logic signed [31:0] sx(input logic [31:0] v);
    logic signed [CW-1:0] t;
    t = v[CW-1:0];
    return 32'(t);
  endfunction

  state_t state_r;
  phase_t phase_r;
  grp_t   grp_r;
  logic [1:0] slot_r;
  logic [1:0] k_r;
  logic [1:0] c_r;
  logic [1:0] term_r;

  logic signed [31:0] pos0_r [3];
  logic signed [31:0] pos1_r [3];
  logic signed [31:0] pos2_r [3];
  logic signed [15:0] n0_r [3];
  logic signed [15:0] n1_r [3];
  logic signed [15:0] n2_r [3];
  logic signed [31:0] uv0_r [2];
  logic signed [31:0] uv1_r [2];
  logic signed [31:0] uv2_r [2];

  logic signed [63:0] g_r [6];
  logic [2:0] idx_r;
  logic [2:0] gn_r;
  logic [63:0] m_r;
  logic [5:0] sh_r;
  logic dir_r;

  logic signed [30:0] e1_r [3];
  logic signed [30:0] e2_r [3];
  logic signed [30:0] dd_r [4];
  logic signed [30:0] w_r [3];
  logic signed [30:0] r_r [3];
  logic signed [47:0] dot_r;
  logic det_neg_r;
  logic det_zero_r;

  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r;

  logic [63:0] sx_r;
  logic [63:0] sres_r;
  logic [4:0]  sb_r;

  logic [45:0] num_r;
  logic [33:0] rem_r;
  logic [15:0] q_r;
  logic [3:0]  qi_r;

  logic signed [15:0] tan_r [3];
  logic deg_r;
  logic out_valid_r;

  // combinational helpers
  logic signed [15:0] nk [3];
  logic [1:0] jj;
  logic [1:0] rix;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic pneg;
  logic [4:0] psh;
  logic last_term;
  logic signed [65:0] pterm;
  logic signed [65:0] acc_nxt;
  logic [63:0] gmag;
  logic [63:0] m_nxt;
  logic signed [63:0] g_sh;
  logic [63:0] sbit;
  logic [63:0] strial;
  logic [31:0] len;
  logic [32:0] den;
  logic [30:0] magr;
  logic [45:0] num_nxt;
  logic [33:0] rem2;
  logic rge;
  logic [15:0] qf;
  logic [15:0] qc;
  logic signed [30:0] rsel;
  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;

  always_comb begin
    unique case (k_r)
      2'd0: nk = n0_r;
      2'd1: nk = n1_r;
      default: nk = n2_r;
    endcase
  end

  assign jj  = (phase_r == PH_DOT) ? term_r : c_r;
  assign rix = (state_r == ST_MUL) ? term_r : c_r;
  assign rsel = r_r[rix];

  always_comb begin
    opa = '0;
    opb = '0;
    pneg = 1'b0;
    psh = '0;
    last_term = 1'b0;
    unique case (phase_r)
      PH_DET: begin
        last_term = (term_r == 2'd1);
        if (term_r == 2'd0) begin
          opa = 32'(dd_r[0]);
          opb = 32'(dd_r[3]);
        end else begin
          opa = 32'(dd_r[2]);
          opb = 32'(dd_r[1]);
          pneg = 1'b1;
        end
      end
      PH_W: begin
        last_term = (term_r == 2'd1);
        if (term_r == 2'd0) begin
          opa = 32'(e1_r[c_r]);
          opb = 32'(dd_r[3]);
        end else begin
          opa = 32'(e2_r[c_r]);
          opb = 32'(dd_r[1]);
          pneg = 1'b1;
        end
      end
      PH_DOT: begin
        last_term = (term_r == 2'd2);
        opa = 32'(nk[jj]);
        opb = 32'(w_r[jj]);
      end
      PH_R: begin
        last_term = (term_r == 2'd2);
        unique case (term_r)
          2'd0: begin
            opa = 32'(w_r[jj]);
            opb = 32'sd1;
            psh = 5'd28;
          end
          2'd1: begin
            opa = 32'(nk[jj]);
            opb = 32'($signed(dot_r[47:24]));
            pneg = 1'b1;
            psh = 5'd24;
          end
          default: begin
            opa = 32'(nk[jj]);
            opb = {8'd0, dot_r[23:0]};
            pneg = 1'b1;
          end
        endcase
      end
      default: begin
        last_term = (term_r == 2'd2);
        opa = 32'(rsel);
        opb = 32'(rsel);
      end
    endcase
  end

  assign pterm   = 66'(prod_r) <<< psh;
  assign acc_nxt = pneg ? (acc_r - pterm) : (acc_r + pterm);

  assign gmag  = g_r[idx_r][63] ? 64'(-g_r[idx_r]) : 64'(g_r[idx_r]);
  assign m_nxt = (gmag > m_r) ? gmag : m_r;
  assign g_sh  = dir_r ? (g_r[idx_r] >>> sh_r) : (g_r[idx_r] <<< sh_r);

  assign sbit   = 64'd1 << {sb_r, 1'b0};
  assign strial = sres_r + sbit;

  assign len     = sres_r[31:0];
  assign den     = {len, 1'b0};
  assign magr    = rsel[30] ? 31'(-rsel) : 31'(rsel);
  assign num_nxt = (46'(magr) << 15) + 46'(len);
  assign rem2    = {rem_r[32:0], num_r[qi_r]};
  assign rge     = (rem2 >= 34'(den));
  assign qf      = {q_r[14:0], rge};
  assign qc      = (qf > ONE_Q) ? ONE_Q : qf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_DET;
      grp_r       <= GRP_E;
      slot_r      <= '0;
      k_r         <= '0;
      c_r         <= '0;
      term_r      <= '0;
      idx_r       <= '0;
      gn_r        <= '0;
      sh_r        <= '0;
      dir_r       <= 1'b0;
      sb_r        <= '0;
      qi_r        <= '0;
      det_neg_r   <= 1'b0;
      det_zero_r  <= 1'b0;
      deg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            priority if (slot_r == 2'd2) begin
              pos2_r <= '{sx(in_pos_x), sx(in_pos_y), sx(in_pos_z)};
              n2_r   <= '{in_norm_x, in_norm_y, in_norm_z};
              uv2_r  <= '{sx(in_tex_u), sx(in_tex_v)};
              slot_r <= 2'd0;
              state_r <= ST_LDE;
            end else if (slot_r == 2'd1) begin
              pos1_r <= '{sx(in_pos_x), sx(in_pos_y), sx(in_pos_z)};
              n1_r   <= '{in_norm_x, in_norm_y, in_norm_z};
              uv1_r  <= '{sx(in_tex_u), sx(in_tex_v)};
              slot_r <= 2'd2;
            end else begin
              pos0_r <= '{sx(in_pos_x), sx(in_pos_y), sx(in_pos_z)};
              n0_r   <= '{in_norm_x, in_norm_y, in_norm_z};
              uv0_r  <= '{sx(in_tex_u), sx(in_tex_v)};
              slot_r <= 2'd1;
            end
          end
        end
        ST_LDE: begin
          for (int i = 0; i < 3; i++) begin
            g_r[i]     <= 64'(pos1_r[i]) - 64'(pos0_r[i]);
            g_r[i + 3] <= 64'(pos2_r[i]) - 64'(pos0_r[i]);
          end
          gn_r    <= 3'd6;
          grp_r   <= GRP_E;
          idx_r   <= '0;
          m_r     <= '0;
          k_r     <= '0;
          state_r <= ST_AMAX;
        end
        ST_AMAX: begin
          m_r <= m_nxt;
          if (idx_r == gn_r - 3'd1) begin
            idx_r <= '0;
            sh_r  <= '0;
            dir_r <= (m_nxt >= ALIGN_HI);
            state_r <= (m_nxt == 64'd0) ? ST_ADONE : ST_ASH;
          end else begin
            idx_r <= idx_r + 3'd1;
          end
        end
        ST_ASH: begin
          priority if (m_r >= COARSE_HI) begin
            m_r  <= m_r >> 4;
            sh_r <= sh_r + 6'd4;
          end else if (m_r >= ALIGN_HI) begin
            m_r  <= m_r >> 1;
            sh_r <= sh_r + 6'd1;
          end else if (m_r < COARSE_LO) begin
            m_r  <= m_r << 4;
            sh_r <= sh_r + 6'd4;
          end else if (m_r < ALIGN_LO) begin
            m_r  <= m_r << 1;
            sh_r <= sh_r + 6'd1;
          end else begin
            state_r <= ST_AAPP;
          end
        end
        ST_AAPP: begin
          g_r[idx_r] <= g_sh;
          if (idx_r == gn_r - 3'd1) begin
            state_r <= ST_ADONE;
          end else begin
            idx_r <= idx_r + 3'd1;
          end
        end
        ST_ADONE: begin
          idx_r <= '0;
          m_r   <= '0;
          acc_r <= '0;
          term_r <= '0;
          c_r   <= '0;
          unique case (grp_r)
            GRP_E: begin
              for (int i = 0; i < 3; i++) begin
                e1_r[i] <= 31'(g_r[i]);
                e2_r[i] <= 31'(g_r[i + 3]);
              end
              g_r[0] <= 64'(uv1_r[0]) - 64'(uv0_r[0]);
              g_r[1] <= 64'(uv1_r[1]) - 64'(uv0_r[1]);
              g_r[2] <= 64'(uv2_r[0]) - 64'(uv0_r[0]);
              g_r[3] <= 64'(uv2_r[1]) - 64'(uv0_r[1]);
              gn_r   <= 3'd4;
              grp_r  <= GRP_D;
              state_r <= ST_AMAX;
            end
            GRP_D: begin
              for (int i = 0; i < 4; i++) dd_r[i] <= 31'(g_r[i]);
              phase_r <= PH_DET;
              state_r <= ST_MUL;
            end
            GRP_W: begin
              for (int i = 0; i < 3; i++) w_r[i] <= 31'(g_r[i]);
              phase_r <= PH_DOT;
              state_r <= ST_MUL;
            end
            default: begin
              for (int i = 0; i < 3; i++) r_r[i] <= 31'(g_r[i]);
              phase_r <= PH_LEN;
              state_r <= ST_MUL;
            end
          endcase
        end
        ST_MUL: begin
          prod_r  <= 64'(opa) * 64'(opb);
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          if (!last_term) begin
            acc_r   <= acc_nxt;
            term_r  <= term_r + 2'd1;
            state_r <= ST_MUL;
          end else begin
            acc_r  <= '0;
            term_r <= '0;
            unique case (phase_r)
              PH_DET: begin
                det_neg_r <= acc_nxt[65];
                if (acc_nxt == 66'sd0) begin
                  det_zero_r  <= 1'b1;
                  deg_r       <= 1'b1;
                  tan_r       <= '{16'sd0, 16'sd0, 16'sd0};
                  out_valid_r <= 1'b1;
                  state_r     <= ST_OUT;
                end else begin
                  det_zero_r <= 1'b0;
                  phase_r    <= PH_W;
                  c_r        <= '0;
                  state_r    <= ST_MUL;
                end
              end
              PH_W: begin
                g_r[c_r] <= det_neg_r ? 64'(-acc_nxt) : 64'(acc_nxt);
                if (c_r == 2'd2) begin
                  gn_r    <= 3'd3;
                  grp_r   <= GRP_W;
                  idx_r   <= '0;
                  m_r     <= '0;
                  state_r <= ST_AMAX;
                end else begin
                  c_r     <= c_r + 2'd1;
                  state_r <= ST_MUL;
                end
              end
              PH_DOT: begin
                dot_r   <= acc_nxt[47:0];
                phase_r <= PH_R;
                c_r     <= '0;
                state_r <= ST_MUL;
              end
              PH_R: begin
                g_r[c_r] <= acc_nxt[63:0];
                if (c_r == 2'd2) begin
                  gn_r    <= 3'd3;
                  grp_r   <= GRP_R;
                  idx_r   <= '0;
                  m_r     <= '0;
                  state_r <= ST_AMAX;
                end else begin
                  c_r     <= c_r + 2'd1;
                  state_r <= ST_MUL;
                end
              end
              default: begin
                if (acc_nxt == 66'sd0) begin
                  deg_r       <= 1'b1;
                  tan_r       <= '{16'sd0, 16'sd0, 16'sd0};
                  out_valid_r <= 1'b1;
                  state_r     <= ST_OUT;
                end else begin
                  sx_r    <= acc_nxt[63:0];
                  sres_r  <= '0;
                  sb_r    <= 5'd31;
                  state_r <= ST_SQRT;
                end
              end
            endcase
          end
        end
        ST_SQRT: begin
          if (sx_r >= strial) begin
            sx_r   <= sx_r - strial;
            sres_r <= (sres_r >> 1) + sbit;
          end else begin
            sres_r <= sres_r >> 1;
          end
          if (sb_r == 5'd0) begin
            c_r     <= '0;
            state_r <= ST_DIVI;
          end else begin
            sb_r <= sb_r - 5'd1;
          end
        end
        ST_DIVI: begin
          num_r   <= num_nxt;
          rem_r   <= 34'(num_nxt[45:16]);
          q_r     <= '0;
          qi_r    <= 4'd15;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= rge ? (rem2 - 34'(den)) : rem2;
          q_r   <= qf;
          if (qi_r == 4'd0) begin
            tan_r[c_r] <= rsel[30] ? -$signed(qc) : $signed(qc);
            if (c_r == 2'd2) begin
              deg_r       <= 1'b0;
              out_valid_r <= 1'b1;
              state_r     <= ST_OUT;
            end else begin
              c_r     <= c_r + 2'd1;
              state_r <= ST_DIVI;
            end
          end else begin
            qi_r <= qi_r - 4'd1;
          end
        end
        default: begin
          if (out_acc) begin
            if (k_r == 2'd2) begin
              out_valid_r <= 1'b0;
              state_r     <= ST_IDLE;
            end else begin
              k_r <= k_r + 2'd1;
              if (!det_zero_r) begin
                out_valid_r <= 1'b0;
                phase_r     <= PH_DOT;
                acc_r       <= '0;
                term_r      <= '0;
                state_r     <= ST_MUL;
              end
            end
          end
        end
      endcase
    end
  end

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_tangent_x        = tan_r[0];
  assign out_tangent_y        = tan_r[1];
  assign out_tangent_z        = tan_r[2];
  assign out_degenerate       = deg_r;
  assign out_last_of_triangle = (k_r == 2'd2);

endmodule

### rtl/ttg_checker.sv
// port-level checks for the triangle tangent generator, bound to the top level
// depends on ttg_pkg and triangle_tangent_generator_unit
module ttg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [ttg_pkg::TAN_W-1:0] out_tangent_x,
  input logic signed [ttg_pkg::TAN_W-1:0] out_tangent_y,
  input logic signed [ttg_pkg::TAN_W-1:0] out_tangent_z,
  input logic                             out_degenerate,
  input logic                             out_last_of_triangle
);

  // tangent stays in unit range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_tangent_x) <= ttg_pkg::ONE_Q14 &&
                   $signed(out_tangent_x) >= -ttg_pkg::ONE_Q14 &&
                   $signed(out_tangent_y) <= ttg_pkg::ONE_Q14 &&
                   $signed(out_tangent_y) >= -ttg_pkg::ONE_Q14 &&
                   $signed(out_tangent_z) <= ttg_pkg::ONE_Q14 &&
                   $signed(out_tangent_z) >= -ttg_pkg::ONE_Q14))
    else $error("tangent out of range");

  // degenerate beat carries a zero tangent
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_tangent_x == '0 && out_tangent_y == '0 && out_tangent_z == '0))
    else $error("degenerate beat with nonzero tangent");

  // no input beat taken while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

  // the last beat of a triangle ends the burst
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_of_triangle) |=> !out_valid)
    else $error("result after last beat");

endmodule

bind triangle_tangent_generator_unit ttg_checker u_ttg_checker (.*);
